>>> src/hhw_pkg.sv
// hhw_pkg: shared constants and register codes of the hann/hamming windower
// no dependencies; imported by hhw_step_div, hhw_cos_rom, hann_hamming_windower and the testbench
package hhw_pkg;

	// phase accumulator: 2^PHASE_BITS is one full turn
	localparam int PHASE_BITS = 28;
	localparam int FRAC_BITS  = PHASE_BITS - 2;

	// fixed-point constants
	localparam int ONE_Q16       = 65536;
	localparam int HAMMING_B_Q16 = 30147;
	localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

	// window length after reset
	localparam int RESET_LENGTH = 1024;

	// configuration port
	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 13;

	localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_KIND   = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_LENGTH = 2'd1;

	// window coefficient word, Q16, 0..1.0
	typedef logic [16:0] coef_t;

endpackage

>>> src/hhw_step_div.sv
// hhw_step_div: restoring divider that works out the phase step for a window length
// holds the phase step register; depends on hhw_pkg
module hhw_step_div #(
	parameter int MAX_LENGTH = 4096
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic [$clog2(MAX_LENGTH)-1:0]     divisor,
	output logic                              busy,
	output logic [hhw_pkg::PHASE_BITS-1:0]    step
);
	import hhw_pkg::*;

	localparam int IW = $clog2(MAX_LENGTH);
	localparam int CW = $clog2(PHASE_BITS + 1);
	localparam longint RST_EFF  = (MAX_LENGTH < RESET_LENGTH) ? MAX_LENGTH : RESET_LENGTH;
	localparam longint RST_STEP = ((64'd1 << PHASE_BITS) + (RST_EFF - 1) / 2) / (RST_EFF - 1);

	logic                  busy_q;
	logic [CW-1:0]         cnt_q;
	logic [IW-1:0]         rem_q;
	logic [IW-1:0]         div_q;
	logic [PHASE_BITS:0]   quo_q;
	logic [PHASE_BITS-1:0] step_q;

	logic [IW:0]   trial;
	logic [IW:0]   diff;
	logic          fits;
	logic [IW-1:0] rem_next;

	// one quotient bit per cycle
	always_comb begin
		trial    = {rem_q, quo_q[PHASE_BITS]};
		diff     = trial - {1'b0, div_q};
		fits     = trial >= {1'b0, div_q};
		rem_next = fits ? diff[IW-1:0] : trial[IW-1:0];
	end

	// control and step register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			step_q <= PHASE_BITS'(RST_STEP);
		end else if (start) begin
			cnt_q <= CW'(PHASE_BITS);
			if (divisor == '0) begin
				// length one: no angle advance
				busy_q <= 1'b0;
				step_q <= '0;
			end else begin
				busy_q <= 1'b1;
			end
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
				step_q <= {quo_q[PHASE_BITS-2:0], fits};
			end
		end
	end

	// dividend / quotient shift register and remainder
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			div_q <= divisor;
			quo_q <= {1'b1, PHASE_BITS'(divisor >> 1)};
		end else if (busy_q) begin
			rem_q <= rem_next;
			quo_q <= {quo_q[PHASE_BITS-1:0], fits};
		end
	end

	assign busy = busy_q;
	assign step = step_q;

endmodule

>>> src/hhw_cos_rom.sv
// hhw_cos_rom: quarter-wave cosine table, Q16, with registered read
// table built at elaboration from a Taylor series; depends on hhw_pkg
module hhw_cos_rom #(
	parameter int COS_TABLE_ENTRIES = 1024
) (
	input  logic                                 clk,
	input  logic                                 en,
	input  logic [$clog2(COS_TABLE_ENTRIES+1)-1:0] addr,
	output hhw_pkg::coef_t                       data
);
	import hhw_pkg::*;

	typedef coef_t rom_t [0:COS_TABLE_ENTRIES];

	// cos(pi/2 * k/E) in Q16, 9-term series in Q30
	function automatic rom_t build_rom();
		rom_t            tbl;
		longint unsigned x;
		longint unsigned x2;
		longint unsigned term;
		longint          sum;
		longint          r;
		int              k;
		int              i;
		for (k = 0; k <= COS_TABLE_ENTRIES; k++) begin
			if (k == COS_TABLE_ENTRIES) begin
				tbl[k] = '0;
			end else begin
				x    = (HALF_PI_Q30 * 64'(k)) / 64'(COS_TABLE_ENTRIES);
				x2   = (x * x) >> 30;
				term = 64'd1 << 30;
				sum  = longint'(term);
				for (i = 1; i <= 8; i++) begin
					term = ((term * x2) >> 30) / 64'((2 * i - 1) * (2 * i));
					if (i[0]) begin
						sum = sum - longint'(term);
					end else begin
						sum = sum + longint'(term);
					end
				end
				if (sum < 0) begin
					sum = 0;
				end
				r = (sum + 8192) >>> 14;
				if (r > ONE_Q16) begin
					r = ONE_Q16;
				end
				tbl[k] = 17'(r);
			end
		end
		return tbl;
	endfunction

	localparam rom_t COS_ROM = build_rom();

	coef_t data_q;

	// synchronous read
	always_ff @(posedge clk) begin
		if (en) begin
			data_q <= COS_ROM[addr];
		end
	end

	assign data = data_q;

endmodule

>>> src/hann_hamming_windower.sv
// hann_hamming_windower: an input transfer passes stage 1, stage 2 and the output register
// to output valid; one sample per cycle sustained; an output stall holds the whole pipeline.
// a window_length write reruns the step divider, with input stalled while it is busy.
// reset (arst_n, async): pipeline empty, index and phase 0, Hann, length 1024.
module hann_hamming_windower #(
	parameter int MAX_LENGTH        = 4096,
	parameter int COS_TABLE_ENTRIES = 1024,
	parameter int SAMPLE_BITS       = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// configuration
	input  logic                            cfg_write,
	input  logic [hhw_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [hhw_pkg::CFG_DATA_W-1:0]  cfg_data,
	// input channel
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic signed [SAMPLE_BITS-1:0]   sample_in,
	input  logic                            frame_end_in,
	// output channel
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic signed [SAMPLE_BITS-1:0]   windowed_sample,
	output logic                            frame_end_out,
	output logic                            size_error
);
	import hhw_pkg::*;

	localparam int IW = $clog2(MAX_LENGTH);
	localparam int AW = $clog2(COS_TABLE_ENTRIES + 1);
	localparam int LW = ($clog2(MAX_LENGTH + 1) > CFG_DATA_W) ?
	                    $clog2(MAX_LENGTH + 1) : CFG_DATA_W;
	localparam int SB = SAMPLE_BITS;
	localparam int RST_EFF = (MAX_LENGTH < RESET_LENGTH) ? MAX_LENGTH : RESET_LENGTH;
	localparam logic signed [SB+1:0] SMAX = (SB+2)'((64'd1 << (SB - 1)) - 1);
	localparam logic signed [SB+1:0] SMIN = ~SMAX;

	// configuration and frame state
	logic                  kind_q;
	logic [IW-1:0]         eff_m1_q;
	logic [IW-1:0]         index_q;
	logic [PHASE_BITS-1:0] phase_q;

	// step divider
	logic                  div_start;
	logic                  div_busy;
	logic [PHASE_BITS-1:0] step;
	logic [LW-1:0]         len_w;
	logic [LW-1:0]         eff_len;
	logic [IW-1:0]         eff_m1;

	// handshake
	logic advance;
	logic in_xfer;
	logic last;
	logic err;

	// stage 0 address
	logic [1:0]            quad;
	logic [FRAC_BITS-1:0]  frac;
	logic [FRAC_BITS+AW-1:0] frac_scaled;
	logic [AW-1:0]         addr_a;
	logic [AW-1:0]         rom_addr;
	coef_t                 rom_data;

	// stage 1
	logic                  valid_s1;
	logic signed [SB-1:0]  sample_s1;
	logic                  end_s1;
	logic                  err_s1;
	logic                  kind_s1;
	logic                  one_s1;
	logic                  neg_s1;
	logic [17:0]           c_off;
	logic [17:0]           hann_num;
	logic [32:0]           hamm_prod;
	coef_t                 w_hann;
	coef_t                 w_hamm;
	coef_t                 w_sel;

	// stage 2
	logic                  valid_s2;
	logic signed [SB-1:0]  sample_s2;
	logic                  end_s2;
	logic                  err_s2;
	coef_t                 w_s2;
	logic signed [SB+17:0] prod;
	logic signed [SB+17:0] prod_rnd;
	logic signed [SB+1:0]  rounded;
	logic signed [SB-1:0]  clamped;

	// output register
	logic                  out_valid_q;
	logic signed [SB-1:0]  windowed_sample_q;
	logic                  frame_end_q;
	logic                  size_error_q;

	// effective length from the write data
	always_comb begin
		len_w = LW'(cfg_data);
		if (len_w == '0) begin
			eff_len = LW'(1);
		end else if (len_w > LW'(MAX_LENGTH)) begin
			eff_len = LW'(MAX_LENGTH);
		end else begin
			eff_len = len_w;
		end
		eff_m1    = IW'(eff_len - LW'(1));
		div_start = cfg_write && (cfg_index == REG_WINDOW_LENGTH);
	end

	hhw_step_div #(
		.MAX_LENGTH(MAX_LENGTH)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.divisor(eff_m1),
		.busy   (div_busy),
		.step   (step)
	);

	// handshake and frame position
	always_comb begin
		advance  = !out_valid_q || !out_stall;
		in_stall = div_busy || !advance;
		in_xfer  = in_valid && !in_stall;
		last     = index_q >= eff_m1_q;
		err      = frame_end_in ^ last;
	end

	// configuration registers, index and phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_q   <= 1'b0;
			eff_m1_q <= IW'(RST_EFF - 1);
			index_q  <= '0;
			phase_q  <= '0;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_WINDOW_KIND: begin
					kind_q <= cfg_data[0];
				end
				REG_WINDOW_LENGTH: begin
					eff_m1_q <= eff_m1;
					index_q  <= '0;
					phase_q  <= '0;
				end
				default: begin
				end
			endcase
		end else if (in_xfer) begin
			if (frame_end_in || last) begin
				index_q <= '0;
				phase_q <= '0;
			end else begin
				index_q <= index_q + 1'b1;
				phase_q <= phase_q + step;
			end
		end
	end

	// quadrant fold of the phase into a rom address
	always_comb begin
		quad        = phase_q[PHASE_BITS-1 -: 2];
		frac        = phase_q[FRAC_BITS-1:0];
		frac_scaled = (FRAC_BITS+AW)'(frac) * (FRAC_BITS+AW)'(COS_TABLE_ENTRIES);
		addr_a      = frac_scaled[FRAC_BITS+AW-1:FRAC_BITS];
		rom_addr    = quad[0] ? (AW'(COS_TABLE_ENTRIES) - addr_a) : addr_a;
	end

	hhw_cos_rom #(
		.COS_TABLE_ENTRIES(COS_TABLE_ENTRIES)
	) u_rom (
		.clk (clk),
		.en  (advance),
		.addr(rom_addr),
		.data(rom_data)
	);

	// pipeline valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (advance) begin
			valid_s1    <= in_xfer;
			valid_s2    <= valid_s1;
			out_valid_q <= valid_s2;
		end
	end

	// stage 1 capture, alongside the rom read
	always_ff @(posedge clk) begin
		if (advance) begin
			sample_s1 <= sample_in;
			end_s1    <= frame_end_in;
			err_s1    <= err;
			kind_s1   <= kind_q;
			one_s1    <= eff_m1_q == '0;
			neg_s1    <= quad[1] ^ quad[0];
		end
	end

	// coefficient from the cosine word
	always_comb begin
		c_off     = neg_s1 ? (18'(ONE_Q16) - {1'b0, rom_data})
		                   : (18'(ONE_Q16) + {1'b0, rom_data});
		hann_num  = 18'(2 * ONE_Q16 + 1) - c_off;
		w_hann    = hann_num[17:1];
		hamm_prod = 33'(HAMMING_B_Q16) * 33'(c_off) + 33'(32768);
		w_hamm    = coef_t'(ONE_Q16) - hamm_prod[32:16];
		if (one_s1) begin
			w_sel = coef_t'(ONE_Q16);
		end else if (kind_s1) begin
			w_sel = w_hamm;
		end else begin
			w_sel = w_hann;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			sample_s2 <= sample_s1;
			end_s2    <= end_s1;
			err_s2    <= err_s1;
			w_s2      <= w_sel;
		end
	end

	// sample times coefficient, round half up, clamp
	always_comb begin
		prod     = sample_s2 * $signed({1'b0, w_s2});
		prod_rnd = prod + $signed((SB+18)'(32768));
		rounded  = prod_rnd[SB+17:16];
		if (rounded > SMAX) begin
			clamped = SB'(SMAX);
		end else if (rounded < SMIN) begin
			clamped = SB'(SMIN);
		end else begin
			clamped = SB'(rounded);
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			windowed_sample_q <= clamped;
			frame_end_q       <= end_s2;
			size_error_q      <= err_s2;
		end
	end

	assign out_valid       = out_valid_q;
	assign windowed_sample = windowed_sample_q;
	assign frame_end_out   = frame_end_q;
	assign size_error      = size_error_q;

	// frame position never runs past the configured length
	a_index_range: assert property (@(posedge clk) disable iff (!arst_n)
		index_q <= eff_m1_q)
		else $error("sample index beyond frame length");

	// frame end or last index restarts index and phase
	a_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(in_xfer && (frame_end_in || last)) |=> (index_q == '0 && phase_q == '0))
		else $error("frame restart missed");

	// length one leaves the angle at zero once the divider is done
	a_len_one_step: assert property (@(posedge clk) disable iff (!arst_n)
		(!div_busy && eff_m1_q == '0) |-> (step == '0))
		else $error("nonzero step for length one");

endmodule

>>> tb/testbench.sv
`timescale 1ns / 100ps
// testbench: self-checking stream test of hann_hamming_windower, directed then random
// depends on hhw_pkg and the windower rtl; expected results come from a built-in predictor
module testbench;
	import hhw_pkg::*;

	localparam int MAX_LEN   = 4096;
	localparam int ROM_SIZE  = 1024;
	localparam int SAMPLE_W  = 16;
	localparam int ITEM_GOAL = 1100;
	localparam int IDLE_PCT  = 34;
	localparam int LONG_HOLD = 150;
	localparam int SETTLE    = 8;
	localparam int MAX_SHOWN = 200;

	localparam logic KIND_HANN    = 1'b0;
	localparam logic KIND_HAMMING = 1'b1;
	localparam logic [CFG_INDEX_W-1:0] REG_SPARE = 2'd3;

	localparam longint SAMPLE_MAX = (longint'(1) << (SAMPLE_W - 1)) - 1;
	localparam longint SAMPLE_MIN = -SAMPLE_MAX - 1;

	typedef struct packed {
		logic [SAMPLE_W-1:0] sample;
		logic                frame_end;
	} audio_item_t;

	typedef struct packed {
		logic [SAMPLE_W-1:0] windowed;
		logic                frame_end;
		logic                size_error;
	} windowed_item_t;

	logic                        clk;
	logic                        arst_n       = 1'b0;
	logic                        cfg_write    = 1'b0;
	logic [CFG_INDEX_W-1:0]      cfg_index    = '0;
	logic [CFG_DATA_W-1:0]       cfg_data     = '0;
	logic                        in_valid     = 1'b0;
	logic                        in_stall;
	logic signed [SAMPLE_W-1:0]  sample_in    = '0;
	logic                        frame_end_in = 1'b0;
	logic                        out_valid;
	logic                        out_stall    = 1'b0;
	logic signed [SAMPLE_W-1:0]  windowed_sample;
	logic                        frame_end_out;
	logic                        size_error;

	// predictor state and its copy of the registers
	logic [16:0]           quarter_cos [0:ROM_SIZE];
	logic                  kind_sel;
	logic [CFG_DATA_W-1:0] length_reg;
	int unsigned           frame_pos;
	logic [PHASE_BITS-1:0] phase_acc;
	logic [PHASE_BITS-1:0] phase_incr;

	audio_item_t    samples_to_send [$];
	windowed_item_t windowed_due [$];
	audio_item_t    next_item;
	audio_item_t    offered;
	windowed_item_t due;

	logic sample_taken  = 1'b0;
	logic steady        = 1'b0;
	logic long_hold_req = 1'b0;
	logic hold_begun    = 1'b0;
	int   hold_left     = 0;
	int   mismatches    = 0;
	int   items_queued  = 0;

	hann_hamming_windower #(
		.MAX_LENGTH(MAX_LEN),
		.COS_TABLE_ENTRIES(ROM_SIZE),
		.SAMPLE_BITS(SAMPLE_W)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.sample_in(sample_in),
		.frame_end_in(frame_end_in),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.windowed_sample(windowed_sample),
		.frame_end_out(frame_end_out),
		.size_error(size_error)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// effective frame length: zero acts as one, clamped at the maximum
	function automatic int unsigned frame_span(input logic [CFG_DATA_W-1:0] len);
		if (len == 0)
			return 1;
		if (len > MAX_LEN)
			return MAX_LEN;
		return len;
	endfunction

	// phase advance per sample, one turn over span-1 samples, rounded to nearest
	function automatic logic [PHASE_BITS-1:0] phase_advance(input int unsigned span);
		longint unsigned d;
		if (span < 2)
			return '0;
		d = span - 1;
		return PHASE_BITS'(((64'd1 << PHASE_BITS) + d / 2) / d);
	endfunction

	// quarter-wave cosine in q16, taylor series in q30
	function automatic logic [16:0] cos_q16(input longint unsigned k);
		longint unsigned x;
		longint unsigned x2;
		longint unsigned term;
		longint unsigned div;
		longint unsigned r;
		longint          acc;
		int              i;
		if (k >= ROM_SIZE)
			return '0;
		x = (HALF_PI_Q30 * k) / ROM_SIZE;
		x2 = (x * x) >> 30;
		term = 64'd1 << 30;
		acc = $signed(term);
		for (i = 1; i <= 8; i++) begin
			div = (2 * i - 1) * (2 * i);
			term = ((term * x2) >> 30) / div;
			if (i % 2 == 1)
				acc = acc - $signed(term);
			else
				acc = acc + $signed(term);
		end
		if (acc < 0)
			acc = 0;
		r = ($unsigned(acc) + 64'd8192) >> 14;
		if (r > ONE_Q16)
			r = ONE_Q16;
		return r[16:0];
	endfunction

	// cosine of the phase plus one, q16, 0..2.0
	function automatic longint unsigned cos_plus_one(input logic [PHASE_BITS-1:0] ph);
		longint unsigned f;
		longint unsigned a;
		f = ph[FRAC_BITS-1:0];
		a = (f * ROM_SIZE) >> FRAC_BITS;
		case (ph[PHASE_BITS-1 -: 2])
			2'd0: return ONE_Q16 + quarter_cos[a];
			2'd1: return ONE_Q16 - quarter_cos[ROM_SIZE - a];
			2'd2: return ONE_Q16 - quarter_cos[a];
			default: return ONE_Q16 + quarter_cos[ROM_SIZE - a];
		endcase
	endfunction

	// window coefficient at the current phase, q16
	function automatic longint unsigned window_coef();
		longint unsigned c;
		if (frame_span(length_reg) == 1)
			return ONE_Q16;
		c = cos_plus_one(phase_acc);
		if (kind_sel == KIND_HAMMING)
			return ONE_Q16 - ((HAMMING_B_Q16 * c + 32768) >> 16);
		return (2 * ONE_Q16 - c + 1) >> 1;
	endfunction

	// expected result of one sample; advances the frame index and the phase
	function automatic windowed_item_t window_sample(input audio_item_t it);
		windowed_item_t res;
		longint         prod;
		longint         rounded;
		logic           at_last;
		prod = longint'($signed(it.sample)) * $signed(window_coef());
		rounded = (prod + 32768) >>> 16;
		if (rounded > SAMPLE_MAX)
			rounded = SAMPLE_MAX;
		if (rounded < SAMPLE_MIN)
			rounded = SAMPLE_MIN;
		at_last = frame_pos >= frame_span(length_reg) - 1;
		res.windowed = rounded[SAMPLE_W-1:0];
		res.frame_end = it.frame_end;
		res.size_error = it.frame_end ? !at_last : at_last;
		if (it.frame_end || at_last) begin
			frame_pos = 0;
			phase_acc = '0;
		end else begin
			frame_pos++;
			phase_acc = phase_acc + phase_incr;
		end
		return res;
	endfunction

	// random sample, often at the extremes or near zero
	function automatic logic [SAMPLE_W-1:0] pick_sample();
		case ($urandom_range(7))
			0: return {1'b0, {(SAMPLE_W-1){1'b1}}};
			1: return {1'b1, {(SAMPLE_W-1){1'b0}}};
			2: return SAMPLE_W'($urandom_range(4) - 2);
			default: return SAMPLE_W'($urandom);
		endcase
	endfunction

	task automatic queue_sample(input logic [SAMPLE_W-1:0] s, input logic fe);
		audio_item_t it;
		it.sample = s;
		it.frame_end = fe;
		samples_to_send.push_back(it);
		items_queued++;
	endtask

	// register write while idle, predictor follows
	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input int unsigned value);
		@(negedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value[CFG_DATA_W-1:0];
		@(negedge clk);
		cfg_write <= 1'b0;
		case (idx)
			REG_WINDOW_KIND: kind_sel = value[0];
			REG_WINDOW_LENGTH: begin
				length_reg = value[CFG_DATA_W-1:0];
				phase_incr = phase_advance(frame_span(length_reg));
				frame_pos = 0;
				phase_acc = '0;
			end
			default: ;
		endcase
		@(posedge clk);
	endtask

	// hold until every queued sample went in and every result came out
	task automatic wait_drained();
		do
			@(negedge clk);
		while (samples_to_send.size() != 0 || in_valid || windowed_due.size() != 0);
		repeat (SETTLE) @(negedge clk);
		@(posedge clk);
	endtask

	// input driver: new transfer offered only after the previous one was taken
	always @(negedge clk) begin
		if (arst_n && (!in_valid || sample_taken)) begin
			if (samples_to_send.size() != 0 && (steady || $urandom_range(99) >= IDLE_PCT)) begin
				next_item = samples_to_send.pop_front();
				in_valid <= 1'b1;
				sample_in <= next_item.sample;
				frame_end_in <= next_item.frame_end;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// output stall: random, or one long hold-off on request
	always @(negedge clk) begin
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else if (long_hold_req && !hold_begun) begin
			hold_begun = 1'b1;
			hold_left = LONG_HOLD;
			out_stall <= 1'b1;
		end else begin
			out_stall <= !steady && ($urandom_range(99) < IDLE_PCT);
		end
	end

	// monitor: predict on input transfer, compare on output transfer
	always @(posedge clk) begin
		if (arst_n) begin
			sample_taken <= in_valid && !in_stall;
			if (in_valid && !in_stall) begin
				offered.sample = sample_in;
				offered.frame_end = frame_end_in;
				windowed_due.push_back(window_sample(offered));
			end
			if (out_valid && !out_stall) begin
				if (windowed_due.size() == 0) begin
					mismatches++;
					if (mismatches <= MAX_SHOWN)
						$display("%0t: output transfer with nothing expected, sample %0d",
							$time, windowed_sample);
				end else begin
					due = windowed_due.pop_front();
					if ({windowed_sample, frame_end_out, size_error} !==
						{due.windowed, due.frame_end, due.size_error}) begin
						mismatches++;
						if (mismatches <= MAX_SHOWN)
							$display({"%0t: mismatch, expected sample %0d end %b error %b,",
								" actual sample %0d end %b error %b"}, $time,
								$signed(due.windowed), due.frame_end, due.size_error,
								windowed_sample, frame_end_out, size_error);
					end
				end
			end
		end
	end

	// stimulus
	initial begin
		int          k;
		int          j;
		int          n;
		int          count;
		int          budget;
		int          sel;
		int          phase_no;
		int unsigned len;
		int unsigned span;

		for (k = 0; k <= ROM_SIZE; k++)
			quarter_cos[k] = cos_q16(k);
		kind_sel = KIND_HANN;
		length_reg = RESET_LENGTH;
		frame_pos = 0;
		phase_acc = '0;
		phase_incr = phase_advance(frame_span(length_reg));

		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset setting, frame cut short at index 4
		queue_sample(16'h7fff, 1'b0);
		queue_sample(16'h8000, 1'b0);
		queue_sample(16'h0001, 1'b0);
		queue_sample(16'hffff, 1'b0);
		queue_sample(16'h7fff, 1'b1);
		wait_drained();

		// hamming, length 3: a proper frame, then one with its end missing
		write_reg(REG_WINDOW_KIND, KIND_HAMMING);
		write_reg(REG_WINDOW_LENGTH, 3);
		queue_sample(16'h7fff, 1'b0);
		queue_sample(16'h8000, 1'b0);
		queue_sample(16'h7fff, 1'b1);
		queue_sample(16'h0001, 1'b0);
		queue_sample(16'hffff, 1'b0);
		queue_sample(16'h5555, 1'b0);
		wait_drained();

		// hann at the same length, kind change alone
		write_reg(REG_WINDOW_KIND, KIND_HANN);
		queue_sample(16'h7fff, 1'b0);
		queue_sample(16'h8000, 1'b0);
		queue_sample(16'h7fff, 1'b1);
		wait_drained();

		// length 1: coefficient one, every sample without an end is an error
		write_reg(REG_WINDOW_LENGTH, 1);
		queue_sample(16'h7fff, 1'b1);
		queue_sample(16'h8000, 1'b0);
		wait_drained();

		// length 0 acts as 1
		write_reg(REG_WINDOW_LENGTH, 0);
		queue_sample(16'h1234, 1'b1);
		wait_drained();

		// length beyond the maximum is clamped
		write_reg(REG_WINDOW_LENGTH, 8191);
		queue_sample(16'h7fff, 1'b0);
		queue_sample(16'h8000, 1'b0);
		queue_sample(16'h5555, 1'b1);
		wait_drained();

		// unused register index is ignored; then length 2
		write_reg(REG_SPARE, 8191);
		write_reg(REG_WINDOW_LENGTH, 2);
		queue_sample(16'haaaa, 1'b0);
		queue_sample(16'h7fff, 1'b1);
		wait_drained();

		// random phases, each under a possibly new setting; the steady and long hold phases always run
		phase_no = 0;
		while (items_queued < ITEM_GOAL || phase_no < 5) begin
			if ($urandom_range(99) < 60)
				write_reg(REG_WINDOW_KIND, $urandom_range(1));
			if (phase_no == 0 || $urandom_range(99) < 80) begin
				sel = $urandom_range(99);
				if (sel < 50)
					len = $urandom_range(16, 1);
				else if (sel < 75)
					len = $urandom_range(128, 17);
				else if (sel < 85)
					len = $urandom_range(600, 129);
				else begin
					case ($urandom_range(7))
						0: len = 0;
						1: len = 1;
						2: len = 2;
						3: len = 3;
						4: len = MAX_LEN - 1;
						5: len = MAX_LEN;
						6: len = MAX_LEN + 1;
						default: len = 8191;
					endcase
				end
				write_reg(REG_WINDOW_LENGTH, len);
			end

			budget = $urandom_range(120, 30);
			if (phase_no == 2) begin
				steady = 1'b1;
				budget = 200;
			end
			if (phase_no == 4) begin
				long_hold_req = 1'b1;
				budget = 160;
			end

			span = frame_span(length_reg);
			count = 0;
			while (count < budget) begin
				sel = $urandom_range(99);
				if (sel < 75 && span <= 600) begin
					// well-formed frame
					for (j = 0; j < span; j++)
						queue_sample(pick_sample(), j == span - 1);
					count += span;
				end else if (sel < 85 || span > 600) begin
					// frame cut short by an early end
					n = $urandom_range((span > 200) ? 200 : span, 1);
					for (j = 0; j < n; j++)
						queue_sample(pick_sample(), j == n - 1);
					count += n;
				end else if (sel < 93) begin
					// frame whose end mark never comes
					for (j = 0; j < span; j++)
						queue_sample(pick_sample(), 1'b0);
					count += span;
				end else begin
					// stray end marks, then an end to realign
					n = $urandom_range(8, 1);
					for (j = 0; j < n; j++)
						queue_sample(pick_sample(), $urandom_range(3) == 0);
					queue_sample(pick_sample(), 1'b1);
					count += n + 1;
				end
			end
			wait_drained();
			steady = 1'b0;
			phase_no++;
		end

		if (mismatches == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

	// run limit
	initial begin
		#1000000;
		$display("FAILURE");
		$finish;
	end

endmodule

>>> files.f
src/hhw_pkg.sv
src/hhw_step_div.sv
src/hhw_cos_rom.sv
src/hann_hamming_windower.sv
tb/testbench.sv
